@@ hdl/lcfr_pkg.sv @@
// Shared types and constants for the LED command frame receiver.
// Used by the core, the parser and the output buffer; has no dependencies of its own.
package lcfr_pkg;

    // Frame layout defaults and fixed byte values.
    localparam int          FRAME_LEN_DEF = 7;
    localparam logic [7:0]  SYNC_FIRST    = 8'h55;
    localparam logic [7:0]  SYNC_SECOND   = 8'hAA;
    localparam logic [7:0]  LED_FUNC      = 8'h06;
    localparam int          POS_FUNC      = 3;
    localparam int          POS_LED       = 4;
    localparam int          POS_STATE     = 5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_CSUM_ERR = 2'd0,
        ST_LED_CMD  = 2'd1,
        ST_OTHER    = 2'd2
    } t_status;

    // One result item as it moves from the parser to the output buffer.
    typedef struct packed {
        t_status    status;
        logic [7:0] func_code;
        logic [7:0] led_number;
        logic       led_on;
    } t_result;

endpackage

@@ hdl/led_command_frame_receiver_core.sv @@
// LED command frame receiver: checks received UART bytes for sync-header
// frames with an XOR checksum and reports one result per completed frame.
//
// Input channel: one byte per transfer on i_rx_byte (i_rx_valid / o_rx_stall).
// Output channel: one result per frame on o_frame_status, o_func_code,
// o_led_number and o_led_on (o_res_valid / i_res_stall). Status 0 means a
// checksum mismatch, 1 an LED command, 2 any other function code.
//
// Throughput is one byte per cycle while the output buffer has room. A byte
// is registered on acceptance and decoded when it advances into the parser;
// the result of a checksum byte is registered into the output buffer. The
// output side is a result register with a skid entry, so bytes keep flowing
// while one result waits. If the receiver stalls long enough for both
// entries to fill, o_rx_stall rises and holds the input until the result
// register drains.
//
// Reset (synchronous, active low) returns the parser to waiting for the
// first sync byte, clears the checksum and field registers, and empties
// both the input register and the output buffer.
module led_command_frame_receiver_core #(
    parameter int FRAME_LEN = lcfr_pkg::FRAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [1:0] o_frame_status,
    output logic [7:0] o_func_code,
    output logic [7:0] o_led_number,
    output logic       o_led_on
);
    import lcfr_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       adv;
    logic       buf_full;
    logic       res_push;
    t_result    res_data;
    t_result    out_data;

    // A byte advances into the parser when the output buffer has room.
    assign adv = in_valid && !buf_full;

    lcfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .i_byte  (i_rx_byte),
        .o_stall (o_rx_stall),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    lcfr_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (in_byte),
        .o_res_valid (res_push),
        .o_res       (res_data)
    );

    lcfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (buf_full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_data  (out_data)
    );

    assign o_frame_status = out_data.status;
    assign o_func_code    = out_data.func_code;
    assign o_led_number   = out_data.led_number;
    assign o_led_on       = out_data.led_on;

endmodule

@@ hdl/lcfr_in_reg.sv @@
// Input register stage of the LED command frame receiver.
// Holds one received byte until the parser takes it; uses no package items.
module lcfr_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_stall,
    input  logic       i_adv,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       load;

    // The stage takes a new transfer whenever it is empty or is draining.
    assign o_stall = r_valid && !i_adv;
    assign load    = i_valid && !o_stall;
    assign n_valid = load || (r_valid && !i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ hdl/lcfr_parser.sv @@
// Frame position tracker, running XOR and result decode.
// Depends on lcfr_pkg for the frame constants and the result type.
module lcfr_parser #(
    parameter int FRAME_LEN = lcfr_pkg::FRAME_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output lcfr_pkg::t_result o_res
);
    import lcfr_pkg::*;

    localparam int          POS_W    = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_led, n_led;
    logic [7:0]       r_state, n_state;
    logic             last;

    assign last = (r_pos >= LAST_POS);

    // Next-state logic for one byte.
    always_comb begin
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_func      = r_func;
        n_led       = r_led;
        n_state     = r_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_adv) begin
            priority if (r_pos == POS_W'(0)) begin
                if (i_byte == SYNC_FIRST) begin
                    n_xor = i_byte;
                    n_pos = POS_W'(1);
                end else begin
                    n_xor = '0;
                    n_pos = '0;
                end
            end else if (r_pos == POS_W'(1)) begin
                if (i_byte == SYNC_SECOND) begin
                    n_xor = r_xor ^ i_byte;
                    n_pos = POS_W'(2);
                end else begin
                    n_xor = '0;
                    n_pos = '0;
                end
            end else if (last) begin
                // Final byte is the checksum: decide the frame outcome.
                o_res_valid = 1'b1;
                if (r_xor != i_byte) begin
                    o_res.status = ST_CSUM_ERR;
                end else if (r_func == LED_FUNC) begin
                    o_res.status     = ST_LED_CMD;
                    o_res.func_code  = r_func;
                    o_res.led_number = r_led;
                    o_res.led_on     = (r_state != 8'd0);
                end else begin
                    o_res.status    = ST_OTHER;
                    o_res.func_code = r_func;
                end
                n_xor = '0;
                n_pos = '0;
            end else begin
                // Body byte: fold into the checksum and keep the fields.
                n_xor = r_xor ^ i_byte;
                if (r_pos == POS_W'(POS_FUNC)) begin
                    n_func = i_byte;
                end
                if (r_pos == POS_W'(POS_LED)) begin
                    n_led = i_byte;
                end
                if (r_pos == POS_W'(POS_STATE)) begin
                    n_state = i_byte;
                end
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_xor   <= '0;
            r_func  <= '0;
            r_led   <= '0;
            r_state <= '0;
        end else begin
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_func  <= n_func;
            r_led   <= n_led;
            r_state <= n_state;
        end
    end

    // The position never runs past the checksum byte.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("frame position beyond last byte");

    // A result always ends the frame.
    a_res_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == '0 && r_xor == '0))
        else $error("frame state not cleared after result");

endmodule

@@ hdl/lcfr_out_buf.sv @@
// Two-entry output buffer (result register plus skid register).
// Depends on lcfr_pkg for the result type.
module lcfr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcfr_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output lcfr_pkg::t_result o_data
);
    import lcfr_pkg::*;

    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop    = r_main_v && !i_stall;
    assign o_full = r_skid_v;

    // Refill the result register from the skid entry first, then the push.
    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (pop) begin
            if (r_skid_v) begin
                n_main   = r_skid;
                n_main_v = 1'b1;
                n_skid_v = i_push;
                n_skid   = i_data;
            end else begin
                n_main   = i_data;
                n_main_v = i_push;
            end
        end else if (i_push) begin
            if (!r_main_v) begin
                n_main   = i_data;
                n_main_v = 1'b1;
            end else begin
                n_skid   = i_data;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // The skid entry is only used behind a waiting result.
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry valid with empty result register");

    // No result arrives while both entries are taken.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_v)
        else $error("result pushed into full buffer");

endmodule
